// ----- sv/sslg_pkg.sv -----
// Shared types and constants for the servo slew limiter with grip lock.
// Used by the channel interfaces, the pulse lane and the top level.
`default_nettype none

package sslg_pkg;

  localparam int unsigned MAX_JOINTS  = 7;
  localparam int unsigned ANGLE_W     = 8;
  localparam int unsigned REQ_W       = 16;
  localparam int unsigned LEVEL_W     = 12;
  localparam int unsigned PULSE_W     = 12;
  localparam int unsigned STREAK_W    = 4;
  localparam int unsigned SAMPLE_BITS = 12;
  localparam int unsigned PROD_W      = ANGLE_W + PULSE_W;
  localparam int unsigned CFG_IDX_W   = 3;

  localparam logic [ANGLE_W-1:0]  ANGLE_FULL = ANGLE_W'(180);
  localparam logic [ANGLE_W-1:0]  ANGLE_HOME = ANGLE_W'(90);
  localparam logic [STREAK_W-1:0] STREAK_MAX = '1;
  localparam logic [LEVEL_W-1:0]  SAMPLE_MASK = LEVEL_W'((1 << SAMPLE_BITS) - 1);

  // Reciprocal of 180 for the angle-to-pulse scaling. The truncated quotient
  // is low by at most one over the product range, and the lane corrects it.
  localparam int unsigned RecipShift = 28;
  localparam int unsigned RECIP_W    = 21;
  localparam logic [RECIP_W-1:0] RECIP_MUL = RECIP_W'((64'd1 << RecipShift) / 180);

  typedef enum logic [2:0] {
    OP_SET_TARGETS = 3'd0,
    OP_HOME        = 3'd1,
    OP_RELAX       = 3'd2,
    OP_TICK        = 3'd3,
    OP_TOUCH       = 3'd4
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRIP_LEVEL    = 3'd0,
    CFG_RELEASE_LEVEL = 3'd1,
    CFG_STREAK_NEEDED = 3'd2,
    CFG_MAX_STEP      = 3'd3,
    CFG_CLOSE_LOWER   = 3'd4,
    CFG_CLAW_JOINT    = 3'd5,
    CFG_PULSE_ZERO    = 3'd6,
    CFG_PULSE_FULL    = 3'd7
  } cfg_idx_e;

  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_LOCKED  = 2'd1;
  localparam logic [1:0] EV_REARMED = 2'd2;

  localparam logic ST_OK        = 1'b0;
  localparam logic ST_NOT_HOMED = 1'b1;

  typedef struct packed {
    logic [2:0]              operation;
    logic signed [REQ_W-1:0] angle_0;
    logic signed [REQ_W-1:0] angle_1;
    logic signed [REQ_W-1:0] angle_2;
    logic signed [REQ_W-1:0] angle_3;
    logic signed [REQ_W-1:0] angle_4;
    logic signed [REQ_W-1:0] angle_5;
    logic signed [REQ_W-1:0] angle_6;
    logic [LEVEL_W-1:0]      touch_level;
  } cmd_t;

  typedef struct packed {
    logic               status;
    logic [1:0]         lock_event;
    logic               grip_locked;
    logic               is_homed;
    logic [PULSE_W-1:0] pulse_0;
    logic [PULSE_W-1:0] pulse_1;
    logic [PULSE_W-1:0] pulse_2;
    logic [PULSE_W-1:0] pulse_3;
    logic [PULSE_W-1:0] pulse_4;
    logic [PULSE_W-1:0] pulse_5;
    logic [PULSE_W-1:0] pulse_6;
  } res_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [LEVEL_W-1:0]   value;
  } cfg_t;

  // Flags of one item as they travel down the pulse pipeline.
  typedef struct packed {
    logic       status;
    logic [1:0] lock_event;
    logic       grip_locked;
    logic       is_homed;
  } meta_t;

  // Load enables of the pulse pipeline stages.
  typedef struct packed {
    logic en2;
    logic en3;
    logic eno;
  } pipe_en_t;

endpackage

`default_nettype wire

// ----- sv/sslg_if.sv -----
// Valid/ready channel interfaces for commands, results and register writes.
// Depends on sslg_pkg for the payload types.
`default_nettype none

interface sslg_cmd_if;
  import sslg_pkg::*;
  logic valid;
  logic ready;
  cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sslg_res_if;
  import sslg_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sslg_cfg_if;
  import sslg_pkg::*;
  logic valid;
  logic ready;
  cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/sslg_pulse_lane.sv -----
// One joint's angle-to-pulse scaling pipeline: multiply, reciprocal divide
// by 180, correction and offset. Depends on sslg_pkg.
`default_nettype none

module sslg_pulse_lane (
  input  wire                       clk_i,
  input  sslg_pkg::pipe_en_t        en_i,
  input  wire [sslg_pkg::ANGLE_W-1:0] angle_i,
  input  wire                       driven_i,
  input  wire [sslg_pkg::PULSE_W-1:0] span_i,
  input  wire [sslg_pkg::PULSE_W-1:0] zero_i,
  input  wire                       rev_i,
  output logic [sslg_pkg::PULSE_W-1:0] pulse_o
);
  import sslg_pkg::*;

  localparam int unsigned RP_W = PROD_W + RECIP_W;

  logic [PROD_W-1:0]  prod2_q, prod3_q;
  logic               drv2_q, drv3_q;
  logic [PULSE_W-1:0] quo3_q;
  logic [PULSE_W-1:0] pulse_q;

  logic [RP_W-1:0]    recip_prod;
  logic [PROD_W-1:0]  rem;
  logic [PULSE_W-1:0] quo_fix;
  logic [PULSE_W-1:0] pulse_d;

  assign recip_prod = RP_W'(prod2_q) * RP_W'(RECIP_MUL);

  // The quotient estimate is exact or one short; the remainder tells which.
  assign rem     = prod3_q - (PROD_W'(quo3_q) * PROD_W'(ANGLE_FULL));
  assign quo_fix = (rem >= PROD_W'(ANGLE_FULL)) ? quo3_q + PULSE_W'(1) : quo3_q;
  assign pulse_d = rev_i ? zero_i - quo_fix : zero_i + quo_fix;

  always_ff @(posedge clk_i) begin
    if (en_i.en2) begin
      prod2_q <= PROD_W'(angle_i) * PROD_W'(span_i);
      drv2_q  <= driven_i;
    end
    if (en_i.en3) begin
      quo3_q  <= recip_prod[RecipShift +: PULSE_W];
      prod3_q <= prod2_q;
      drv3_q  <= drv2_q;
    end
    if (en_i.eno) begin
      pulse_q <= drv3_q ? pulse_d : '0;
    end
  end

  assign pulse_o = pulse_q;

endmodule

`default_nettype wire

// ----- sv/servo_slew_limiter_with_grip_lock_unit.sv -----
// Top level of the servo slew limiter with grip lock: command decode, joint
// state, touch qualifier and the per-joint pulse lanes.
// Depends on sslg_pkg, the channel interfaces and sslg_pulse_lane.
`default_nettype none

// How to use this block:
// Commands arrive on cmd_i, one item per operation (set targets, home, relax,
// motion tick, touch sample). Every accepted item yields exactly one result on
// res_o, carrying status, the lock event, the lock and homed flags after the
// item, and one PWM pulse count per joint (zero for a limp channel).
// Register writes arrive on cfg_i, which is always ready; write them only
// while no item is in flight.
// The joint state is updated in the cycle an item is accepted, so a new item
// can be taken every cycle while the receiver keeps up. The pulse scaling then
// runs through three more registered stages (multiply, reciprocal divide,
// correct and offset) before the result is valid, and the sustained rate is one
// item per cycle while the receiver takes results.
// Each stage holds its item while the stage after it is full, so when the
// receiver stalls the pipeline fills up and cmd_i.ready drops only once all
// four stages hold items; no item is lost or repeated.
// Reset puts every joint at 90 degrees with its goal at 90, all channels
// limp, not homed, unlocked, and the registers at their defaults.

module servo_slew_limiter_with_grip_lock_unit #(
  parameter int unsigned JOINTS = 7
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  sslg_cmd_if.sink   cmd_i,
  sslg_cfg_if.sink   cfg_i,
  sslg_res_if.source res_o
);
  import sslg_pkg::*;

  // Configuration registers.
  logic [LEVEL_W-1:0]  trip_q, release_q;
  logic [STREAK_W-1:0] streak_q;
  logic [ANGLE_W-1:0]  max_step_q;
  logic                close_lower_q;
  logic [2:0]          claw_q;
  logic [PULSE_W-1:0]  pzero_q, pfull_q;
  // Derived from the pulse registers and registered for the lanes.
  logic [PULSE_W-1:0]  span_q;
  logic                rev_q;

  // Joint and gripper state.
  logic [ANGLE_W-1:0]  goal_q [JOINTS];
  logic [ANGLE_W-1:0]  goal_d [JOINTS];
  logic [ANGLE_W-1:0]  now_q  [JOINTS];
  logic [ANGLE_W-1:0]  now_d  [JOINTS];
  logic [JOINTS-1:0]   drv_q, drv_d;
  logic                homed_q, homed_d;
  logic                lock_q, lock_d;
  logic [STREAK_W-1:0] agree_q, agree_d;

  // Pipeline stages.
  logic                v1_q, v2_q, v3_q, vo_q;
  meta_t               meta_d, meta1_q, meta2_q, meta3_q, metao_q;
  logic [ANGLE_W-1:0]  ang1_q [JOINTS];
  logic [JOINTS-1:0]   drv1_q;
  pipe_en_t            pen;
  logic                en1;

  logic                cmd_acc;
  op_e                 cmd_op;
  logic signed [REQ_W-1:0] cmd_ang [MAX_JOINTS];
  logic [ANGLE_W-1:0]  req  [JOINTS];
  logic [ANGLE_W-1:0]  tick [JOINTS];
  logic [JOINTS-1:0]   tighten;
  logic [JOINTS-1:0]   moving;
  logic [LEVEL_W-1:0]  sample;
  logic [STREAK_W-1:0] agree_inc;
  logic                streak_done;
  logic [PULSE_W-1:0]  pulse_w [MAX_JOINTS];

  function automatic logic [ANGLE_W-1:0] clamp_angle(input logic signed [REQ_W-1:0] a);
    logic [ANGLE_W-1:0] r;
    if (a[REQ_W-1]) begin
      r = '0;
    end else if (a > REQ_W'(ANGLE_FULL)) begin
      r = ANGLE_FULL;
    end else begin
      r = a[ANGLE_W-1:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Handshake and stage enables. A stage loads when it is empty or when the
  // stage after it is loading too.
  // ---------------------------------------------------------------------------
  assign pen.eno = !vo_q || res_o.ready;
  assign pen.en3 = !v3_q || pen.eno;
  assign pen.en2 = !v2_q || pen.en3;
  assign en1     = !v1_q || pen.en2;

  assign cmd_i.ready = en1;
  assign cfg_i.ready = 1'b1;
  assign cmd_acc     = cmd_i.valid && en1;
  assign cmd_op      = op_e'(cmd_i.data.operation);

  assign cmd_ang[0] = cmd_i.data.angle_0;
  assign cmd_ang[1] = cmd_i.data.angle_1;
  assign cmd_ang[2] = cmd_i.data.angle_2;
  assign cmd_ang[3] = cmd_i.data.angle_3;
  assign cmd_ang[4] = cmd_i.data.angle_4;
  assign cmd_ang[5] = cmd_i.data.angle_5;
  assign cmd_ang[6] = cmd_i.data.angle_6;

  // ---------------------------------------------------------------------------
  // Configuration writes.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trip_q        <= LEVEL_W'(2048);
      release_q     <= LEVEL_W'(1600);
      streak_q      <= STREAK_W'(3);
      max_step_q    <= ANGLE_W'(2);
      close_lower_q <= 1'b0;
      claw_q        <= 3'd6;
      pzero_q       <= PULSE_W'(102);
      pfull_q       <= PULSE_W'(512);
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.data.index))
        CFG_TRIP_LEVEL:    trip_q        <= cfg_i.data.value;
        CFG_RELEASE_LEVEL: release_q     <= cfg_i.data.value;
        CFG_STREAK_NEEDED: streak_q      <= cfg_i.data.value[STREAK_W-1:0];
        CFG_MAX_STEP:      max_step_q    <= cfg_i.data.value[ANGLE_W-1:0];
        CFG_CLOSE_LOWER:   close_lower_q <= cfg_i.data.value[0];
        CFG_CLAW_JOINT:    claw_q        <= cfg_i.data.value[2:0];
        CFG_PULSE_ZERO:    pzero_q       <= cfg_i.data.value;
        CFG_PULSE_FULL:    pfull_q       <= cfg_i.data.value;
        default: ;
      endcase
    end
  end

  // A reversed range scales downward from the zero-degree count.
  always_ff @(posedge clk_i) begin
    rev_q  <= pfull_q < pzero_q;
    span_q <= (pfull_q < pzero_q) ? pzero_q - pfull_q : pfull_q - pzero_q;
  end

  // ---------------------------------------------------------------------------
  // Per-joint lanes of the state update: clamp, tighten test, slew step.
  // ---------------------------------------------------------------------------
  always_comb begin
    for (int i = 0; i < JOINTS; i++) begin
      req[i]     = clamp_angle(cmd_ang[i]);
      tighten[i] = close_lower_q ? (req[i] < now_q[i]) : (req[i] > now_q[i]);
      moving[i]  = goal_q[i] != now_q[i];
      if (goal_q[i] > now_q[i]) begin
        tick[i] = ((goal_q[i] - now_q[i]) > max_step_q) ? now_q[i] + max_step_q : goal_q[i];
      end else begin
        tick[i] = ((now_q[i] - goal_q[i]) > max_step_q) ? now_q[i] - max_step_q : goal_q[i];
      end
    end
  end

  // Touch qualifier: the streak counts agreeing samples and saturates.
  assign sample      = cmd_i.data.touch_level & SAMPLE_MASK;
  assign agree_inc   = (agree_q != STREAK_MAX) ? agree_q + STREAK_W'(1) : agree_q;
  assign streak_done = agree_inc >= streak_q;

  always_comb begin
    goal_d  = goal_q;
    now_d   = now_q;
    drv_d   = drv_q;
    homed_d = homed_q;
    lock_d  = lock_q;
    agree_d = agree_q;
    meta_d  = '0;
    meta_d.status     = ST_OK;
    meta_d.lock_event = EV_NONE;
    case (cmd_op)
      OP_SET_TARGETS: begin
        if (!homed_q) begin
          meta_d.status = ST_NOT_HOMED;
        end else begin
          // A locked claw keeps any goal that would tighten its grip.
          for (int i = 0; i < JOINTS; i++) begin
            if (!(lock_q && claw_q == 3'(i) && tighten[i])) begin
              goal_d[i] = req[i];
            end
          end
        end
      end
      OP_HOME: begin
        for (int i = 0; i < JOINTS; i++) begin
          goal_d[i] = ANGLE_HOME;
          now_d[i]  = ANGLE_HOME;
        end
        drv_d   = '1;
        homed_d = 1'b1;
        lock_d  = 1'b0;
        agree_d = '0;
      end
      OP_RELAX: begin
        drv_d   = '0;
        homed_d = 1'b0;
      end
      OP_TICK: begin
        if (homed_q) begin
          for (int i = 0; i < JOINTS; i++) begin
            if (moving[i]) begin
              now_d[i] = tick[i];
              drv_d[i] = 1'b1;
            end
          end
        end
      end
      OP_TOUCH: begin
        if (!lock_q && sample > trip_q) begin
          agree_d = agree_inc;
          if (streak_done) begin
            // Freeze the claw where it is; an out-of-range claw index
            // matches no joint.
            for (int i = 0; i < JOINTS; i++) begin
              if (claw_q == 3'(i)) begin
                goal_d[i] = now_q[i];
                drv_d[i]  = 1'b1;
              end
            end
            lock_d            = 1'b1;
            agree_d           = '0;
            meta_d.lock_event = EV_LOCKED;
          end
        end else if (lock_q && sample < release_q) begin
          agree_d = agree_inc;
          if (streak_done) begin
            lock_d            = 1'b0;
            agree_d           = '0;
            meta_d.lock_event = EV_REARMED;
          end
        end else begin
          agree_d = '0;
        end
      end
      default: ;
    endcase
    meta_d.grip_locked = lock_d;
    meta_d.is_homed    = homed_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < JOINTS; i++) begin
        goal_q[i] <= ANGLE_HOME;
        now_q[i]  <= ANGLE_HOME;
      end
      drv_q   <= '0;
      homed_q <= 1'b0;
      lock_q  <= 1'b0;
      agree_q <= '0;
    end else if (cmd_acc) begin
      goal_q  <= goal_d;
      now_q   <= now_d;
      drv_q   <= drv_d;
      homed_q <= homed_d;
      lock_q  <= lock_d;
      agree_q <= agree_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline valid bits and flags. Stage one holds the angles after the item.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en1)     v1_q <= cmd_i.valid;
      if (pen.en2) v2_q <= v1_q;
      if (pen.en3) v3_q <= v2_q;
      if (pen.eno) vo_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      meta1_q <= meta_d;
      ang1_q  <= now_d;
      drv1_q  <= drv_d;
    end
    if (pen.en2) meta2_q <= meta1_q;
    if (pen.en3) meta3_q <= meta2_q;
    if (pen.eno) metao_q <= meta3_q;
  end

  for (genvar j = 0; j < MAX_JOINTS; j++) begin : g_lane
    if (j < JOINTS) begin : g_on
      sslg_pulse_lane u_lane (
        .clk_i    (clk_i),
        .en_i     (pen),
        .angle_i  (ang1_q[j]),
        .driven_i (drv1_q[j]),
        .span_i   (span_q),
        .zero_i   (pzero_q),
        .rev_i    (rev_q),
        .pulse_o  (pulse_w[j])
      );
    end else begin : g_off
      assign pulse_w[j] = '0;
    end
  end

  assign res_o.valid            = vo_q;
  assign res_o.data.status      = metao_q.status;
  assign res_o.data.lock_event  = metao_q.lock_event;
  assign res_o.data.grip_locked = metao_q.grip_locked;
  assign res_o.data.is_homed    = metao_q.is_homed;
  assign res_o.data.pulse_0     = pulse_w[0];
  assign res_o.data.pulse_1     = pulse_w[1];
  assign res_o.data.pulse_2     = pulse_w[2];
  assign res_o.data.pulse_3     = pulse_w[3];
  assign res_o.data.pulse_4     = pulse_w[4];
  assign res_o.data.pulse_5     = pulse_w[5];
  assign res_o.data.pulse_6     = pulse_w[6];

`ifndef SYNTH
  // An accepted item always occupies the first stage on the next cycle.
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_acc |=> v1_q)
    else $error("accepted item did not enter the first stage");

  // Homing leaves the block homed and unlocked.
  a_home_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_acc && (cmd_op == OP_HOME) |=> homed_q && !lock_q && (agree_q == '0))
    else $error("home did not set homed and clear the lock");

  // A rejected set targets can only come from an unhomed block.
  a_reject_unhomed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && (meta1_q.status == ST_NOT_HOMED) |-> !meta1_q.is_homed)
    else $error("set targets rejected while homed");

  // The lock and re-arm events agree with the lock flag they report.
  a_event_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && (meta1_q.lock_event != EV_NONE) |->
      (meta1_q.grip_locked == (meta1_q.lock_event == EV_LOCKED)))
    else $error("lock event disagrees with lock flag");
`endif

endmodule

`default_nettype wire
